// ===== src/i2c_master_register_access_assert.svh =====
// assertion macros for the i2c register access master
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// same-cycle implication outside reset
`define A_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2c master check failed");

// next-cycle implication, also checked across reset
`define A_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("i2c master check failed");

`endif

// ===== src/i2cmra_pkg.sv =====
// shared types and constants of the i2c register access master
// no dependencies
package i2cmra_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_BYTE  = 2'd3
    } t_req;

    localparam logic [1:0] CFG_PHASE_TICKS  = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_ACK_POLL     = 2'd2;

    localparam logic [7:0] PHASE_TICKS_RST  = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd50;
    localparam logic [3:0] ACK_POLL_RST     = 4'd1;

    typedef struct packed {
        t_req       kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] write_byte;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_item_q;

endpackage

// ===== src/i2cmra_front.sv =====
// front end: takes requests, classifies them and queues them (two entries)
// depends on i2cmra_pkg
module i2cmra_front import i2cmra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [31:0] i_tdata,
    input  logic [1:0]  i_tuser,
    output t_item_q     o_head,
    input  logic        i_take
);

    t_item       r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push, w_pop;
    t_item       w_in;

    assign o_tready = (r_count != 2'd2);
    assign w_push   = i_tvalid && o_tready;
    assign w_pop    = i_take && (r_count != 2'd0);

    always_comb begin
        w_in.kind       = t_req'(i_tuser);
        w_in.dev_addr   = i_tdata[6:0];
        w_in.reg_addr   = i_tdata[14:7];
        w_in.length     = i_tdata[22:15];
        w_in.write_byte = i_tdata[30:23];
        w_in.sda_level  = i_tdata[31];
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/i2cmra_back.sv =====
// back end: bus phase sequencer, one queued request per tick, registered result
// depends on i2cmra_pkg
module i2cmra_back import i2cmra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  t_item_q     i_head,
    output logic        o_take,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [15:0] o_tdata
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_TXS, PH_TXH, PH_TXL,
        PH_AKS, PH_AKH, PH_POLL, PH_AKL, PH_WAIT, PH_RXL, PH_RXH, PH_RXE,
        PH_RAS, PH_RAH, PH_RAL, PH_SP1, PH_SP2, PH_SP3, PH_SP4
    } t_phase;

    typedef struct packed {
        t_phase     ph;
        logic [7:0] tick;
        logic [3:0] bitc;
        logic [7:0] sh;
        logic [7:0] left;
        logic [7:0] poll;
        logic       rd;
        logic [6:0] dev;
        logic [7:0] rg;
        logic [1:0] stage;
        logic       failed;
        logic       scl;
        logic       sda;
        logic       dir;
        logic       gv;
        logic       gd;
    } t_bst;

    logic [7:0]  r_phase_ticks, r_ack_timeout;
    logic [3:0]  r_ack_poll;
    t_bst        r_st;
    logic        r_tvalid;
    logic [15:0] r_tdata;
    t_bst        w_s1, w_s2;
    logic        w_scl, w_sda, w_dir, w_need;

    function automatic t_bst f_enter(input t_bst s, input t_phase ph, input logic [7:0] pt);
        t_bst t;
        t      = s;
        t.ph   = ph;
        t.tick = (pt != 8'd0) ? pt : 8'd1;
        case (ph)
            PH_ST1:  begin t.dir = 1'b1; t.sda = 1'b1; end
            PH_ST2:  t.scl = 1'b1;
            PH_ST3:  t.sda = 1'b0;
            PH_ST4:  t.scl = 1'b0;
            PH_TXS:  begin t.dir = 1'b1; t.scl = 1'b0; t.sda = t.sh[7]; end
            PH_TXH:  t.scl = 1'b1;
            PH_TXL:  t.scl = 1'b0;
            PH_AKS:  begin t.dir = 1'b0; t.scl = 1'b0; end
            PH_AKH:  t.scl = 1'b1;
            PH_POLL: begin t.tick = 8'd0; t.poll = 8'd0; end
            PH_AKL:  t.scl = 1'b0;
            PH_RXL:  begin t.dir = 1'b0; t.scl = 1'b0; end
            PH_RXH:  t.scl = 1'b1;
            PH_RXE:  t.scl = 1'b0;
            PH_RAS:  begin t.scl = 1'b0; t.dir = 1'b1; t.sda = (t.left == 8'd0); end
            PH_RAH:  t.scl = 1'b1;
            PH_RAL:  t.scl = 1'b0;
            PH_SP1:  begin t.dir = 1'b1; t.scl = 1'b0; end
            PH_SP2:  t.sda = 1'b0;
            PH_SP3:  t.scl = 1'b1;
            PH_SP4:  t.sda = 1'b1;
            default: t = t;
        endcase
        return t;
    endfunction

    // next data byte of a write, or stop when none is left
    function automatic t_bst f_next_wr(input t_bst s, input logic [7:0] pt);
        t_bst t;
        t = s;
        if (t.left != 8'd0) t.ph = PH_WAIT;
        else t = f_enter(t, PH_SP1, pt);
        return t;
    endfunction

    function automatic t_bst f_phase_end(input t_bst s, input logic sda,
                                         input logic [7:0] pt);
        t_bst t;
        t = s;
        case (s.ph)
            PH_ST1: t = f_enter(t, PH_ST2, pt);
            PH_ST2: t = f_enter(t, PH_ST3, pt);
            PH_ST3: t = f_enter(t, PH_ST4, pt);
            PH_ST4: begin
                t.sh   = {t.dev, (t.stage == 2'd2)};
                t.bitc = 4'd0;
                t      = f_enter(t, PH_TXS, pt);
            end
            PH_TXS: t = f_enter(t, PH_TXH, pt);
            PH_TXH: t = f_enter(t, PH_TXL, pt);
            PH_TXL: begin
                t.sh   = {t.sh[6:0], 1'b0};
                t.bitc = t.bitc + 4'd1;
                if (t.bitc < 4'd8) t = f_enter(t, PH_TXS, pt);
                else t = f_enter(t, PH_AKS, pt);
            end
            PH_AKS: t = f_enter(t, PH_AKH, pt);
            PH_AKH: t = f_enter(t, PH_POLL, pt);
            PH_AKL: begin
                case (t.stage)
                    2'd0: begin
                        t.stage = 2'd1;
                        t.sh    = t.rg;
                        t.bitc  = 4'd0;
                        t       = f_enter(t, PH_TXS, pt);
                    end
                    2'd1: begin
                        if (t.rd) begin
                            t.stage = 2'd2;
                            t       = f_enter(t, PH_ST1, pt);
                        end else begin
                            t.stage = 2'd3;
                            t       = f_next_wr(t, pt);
                        end
                    end
                    2'd2: begin
                        t.stage = 2'd3;
                        if (t.left != 8'd0) begin
                            t.bitc = 4'd0;
                            t      = f_enter(t, PH_RXL, pt);
                        end else begin
                            t = f_enter(t, PH_SP1, pt);
                        end
                    end
                    default: t = f_next_wr(t, pt);
                endcase
            end
            PH_RXL: t = f_enter(t, PH_RXH, pt);
            PH_RXH: begin
                t.sh   = {t.sh[6:0], sda};
                t.bitc = t.bitc + 4'd1;
                if (t.bitc < 4'd8) begin
                    t = f_enter(t, PH_RXL, pt);
                end else begin
                    t.gv   = 1'b1;
                    t.left = t.left - 8'd1;
                    t      = f_enter(t, PH_RXE, pt);
                end
            end
            PH_RXE: t = f_enter(t, PH_RAS, pt);
            PH_RAS: t = f_enter(t, PH_RAH, pt);
            PH_RAH: t = f_enter(t, PH_RAL, pt);
            PH_RAL: begin
                if (t.left != 8'd0) begin
                    t.bitc = 4'd0;
                    t      = f_enter(t, PH_RXL, pt);
                end else begin
                    t = f_enter(t, PH_SP1, pt);
                end
            end
            PH_SP1: t = f_enter(t, PH_SP2, pt);
            PH_SP2: t = f_enter(t, PH_SP3, pt);
            PH_SP3: t = f_enter(t, PH_SP4, pt);
            PH_SP4: begin
                t.ph = PH_IDLE;
                t.gd = 1'b1;
            end
            default: t.ph = PH_IDLE;
        endcase
        return t;
    endfunction

    // request handling first, then the line levels, then the phase timer
    always_comb begin
        w_s1    = r_st;
        w_s1.gv = 1'b0;
        w_s1.gd = 1'b0;
        if (r_st.ph == PH_IDLE &&
            (i_head.item.kind == REQ_WRITE || i_head.item.kind == REQ_READ)) begin
            w_s1.dev    = i_head.item.dev_addr;
            w_s1.rg     = i_head.item.reg_addr;
            w_s1.left   = i_head.item.length;
            w_s1.rd     = (i_head.item.kind == REQ_READ);
            w_s1.failed = 1'b0;
            w_s1.stage  = 2'd0;
            w_s1        = f_enter(w_s1, PH_ST1, r_phase_ticks);
        end else if (r_st.ph == PH_WAIT && i_head.item.kind == REQ_BYTE) begin
            w_s1.sh   = i_head.item.write_byte;
            w_s1.left = w_s1.left - 8'd1;
            w_s1.bitc = 4'd0;
            w_s1      = f_enter(w_s1, PH_TXS, r_phase_ticks);
        end

        w_scl  = w_s1.scl;
        w_dir  = w_s1.dir;
        w_sda  = w_s1.dir ? w_s1.sda : 1'b1;
        w_need = (w_s1.ph == PH_WAIT);

        w_s2 = w_s1;
        if (w_s1.ph == PH_POLL) begin
            if (w_s2.tick != 8'd0) w_s2.tick = w_s2.tick - 8'd1;
            if (w_s2.tick == 8'd0) begin
                if (!i_head.item.sda_level) begin
                    w_s2 = f_enter(w_s2, PH_AKL, r_phase_ticks);
                end else if (w_s2.poll >= r_ack_timeout) begin
                    w_s2.failed = 1'b1;
                    w_s2        = f_enter(w_s2, PH_SP1, r_phase_ticks);
                end else begin
                    w_s2.poll = w_s2.poll + 8'd1;
                    w_s2.tick = (r_ack_poll != 4'd0) ? {4'd0, r_ack_poll} : 8'd1;
                end
            end
        end else if (w_s1.ph != PH_IDLE && w_s1.ph != PH_WAIT) begin
            if (w_s2.tick != 8'd0) w_s2.tick = w_s2.tick - 8'd1;
            if (w_s2.tick == 8'd0) begin
                w_s2 = f_phase_end(w_s2, i_head.item.sda_level, r_phase_ticks);
            end
        end
    end

    assign o_take   = i_head.valid && (!r_tvalid || i_tready);
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
            r_ack_poll    <= ACK_POLL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                CFG_ACK_POLL:    r_ack_poll    <= i_cfg_data[3:0];
                default:         r_ack_poll    <= r_ack_poll;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '{ph: PH_IDLE, scl: 1'b1, sda: 1'b1, dir: 1'b1, default: '0};
            r_tvalid <= 1'b0;
        end else begin
            if (o_take) begin
                r_st     <= w_s2;
                r_tvalid <= 1'b1;
                r_tdata  <= {(w_s2.ph != PH_IDLE), w_s2.gd & w_s2.failed, w_s2.gd,
                             w_need, w_s2.gv, (w_s2.gv ? w_s2.sh : 8'd0),
                             w_dir, w_sda, w_scl};
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/i2c_master_register_access.sv =====
// I2C register access master: one request per tick, one result per tick.
// A request is taken every clock cycle when the result side keeps up; each
// request is one bus timing tick, passing the request queue, then the registered
// sequencer step. Line levels follow the phase timer: phase_ticks requests per
// bus phase, ack_poll per ACK poll step. The user must write configuration through
// the write port only while no request is queued or pending; the block does not
// enforce this. Depends on i2cmra_pkg, i2cmra_front, i2cmra_back.
`include "i2c_master_register_access_assert.svh"
module i2c_master_register_access import i2cmra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // dev_addr[6:0], reg_addr[14:7], length[22:15], write_byte[30:23], sda_level[31]
    input  logic [31:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // scl_level[0], sda_drive[1], sda_is_output[2], read_byte[10:3], read_valid[11],
    // need_write_byte[12], done_res[13], status[14], busy_res[15]
    output logic [15:0] o_m_axis_tdata
);

    t_item_q w_head;
    logic    w_take;

    i2cmra_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .o_head   (w_head),
        .i_take   (w_take)
    );

    i2cmra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_take      (w_take),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata)
    );

    // a finished transaction leaves the bus idle
    `A_IMPL(a_done_idle, o_m_axis_tvalid && o_m_axis_tdata[13], !o_m_axis_tdata[15])
    // error status only with done
    `A_IMPL(a_status_done, o_m_axis_tvalid && o_m_axis_tdata[14], o_m_axis_tdata[13])
    // waiting for write data implies a transaction in progress
    `A_IMPL(a_need_busy, o_m_axis_tvalid && o_m_axis_tdata[12], o_m_axis_tdata[15])
    // nothing is queued or presented right after reset
    `A_NEXT(a_reset_clear, !i_rst_n, !o_m_axis_tvalid && !w_head.valid)

endmodule

// ===== verif/i2c_master_register_access_tb.sv =====
// self-checking testbench for the i2c register access master
// drives stream requests and checks every result against a local bus model or a fixed value
// depends on i2cmra_pkg and the i2c_master_register_access rtl
`timescale 1ns / 100ps
module i2c_master_register_access_tb;
    import i2cmra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ST1, S_ST2, S_ST3, S_ST4, S_TXS, S_TXH, S_TXL, S_AKS, S_AKH,
        S_POLL, S_AKL, S_WAIT, S_RXL, S_RXH, S_RXE, S_RAS, S_RAH, S_RAL,
        S_SP1, S_SP2, S_SP3, S_SP4
    } t_bus_phase;

    typedef struct {
        t_req       kind;
        logic [6:0] dev;
        logic [7:0] regi;
        logic [7:0] len;
        logic [7:0] wbyte;
        logic       sda;
        logic       typed;
        logic [15:0] want;
    } t_row;

    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_PHASE_TICKS;
    logic [7:0]  i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = REQ_TICK;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;

    i2c_master_register_access dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bus model state
    logic [7:0] m_phase_ticks, m_timeout, m_sreg, m_left, m_pcnt, m_tcnt, m_dev, m_regi;
    logic [3:0] m_poll_ticks, m_bcnt;
    logic [1:0] m_stage;
    logic       m_rd, m_fail, m_scl, m_sda, m_dir, m_got_byte, m_got_done;
    t_bus_phase m_ph;

    logic [15:0] line_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int nack_pct = 5;
    int burst_left = 0;
    logic in_accept;

    function automatic void load_phase(t_bus_phase p);
        m_ph = p;
        m_tcnt = (m_phase_ticks != 0) ? m_phase_ticks : 8'd1;
        case (p)
            S_ST1: begin m_dir = 1; m_sda = 1; end
            S_ST2: m_scl = 1;
            S_ST3: m_sda = 0;
            S_ST4: m_scl = 0;
            S_TXS: begin m_dir = 1; m_scl = 0; m_sda = m_sreg[7]; end
            S_TXH: m_scl = 1;
            S_TXL: m_scl = 0;
            S_AKS: begin m_dir = 0; m_scl = 0; end
            S_AKH: m_scl = 1;
            S_POLL: begin m_tcnt = 0; m_pcnt = 0; end
            S_AKL: m_scl = 0;
            S_RXL: begin m_dir = 0; m_scl = 0; end
            S_RXH: m_scl = 1;
            S_RXE: m_scl = 0;
            S_RAS: begin m_scl = 0; m_dir = 1; m_sda = (m_left != 0) ? 1'b0 : 1'b1; end
            S_RAH: m_scl = 1;
            S_RAL: m_scl = 0;
            S_SP1: begin m_dir = 1; m_scl = 0; end
            S_SP2: m_sda = 0;
            S_SP3: m_scl = 1;
            S_SP4: m_sda = 1;
            default: ;
        endcase
    endfunction

    function automatic void next_data_byte();
        if (m_left != 0) m_ph = S_WAIT;
        else load_phase(S_SP1);
    endfunction

    function automatic void phase_done(logic sda);
        case (m_ph)
            S_ST1: load_phase(S_ST2);
            S_ST2: load_phase(S_ST3);
            S_ST3: load_phase(S_ST4);
            S_ST4: begin
                m_sreg = {m_dev[6:0], m_stage == 2'd2};
                m_bcnt = 0;
                load_phase(S_TXS);
            end
            S_TXS: load_phase(S_TXH);
            S_TXH: load_phase(S_TXL);
            S_TXL: begin
                m_sreg = m_sreg << 1;
                m_bcnt++;
                load_phase(m_bcnt < 8 ? S_TXS : S_AKS);
            end
            S_AKS: load_phase(S_AKH);
            S_AKH: load_phase(S_POLL);
            S_AKL: begin
                case (m_stage)
                    2'd0: begin
                        m_stage = 1; m_sreg = m_regi; m_bcnt = 0; load_phase(S_TXS);
                    end
                    2'd1: begin
                        if (m_rd) begin m_stage = 2; load_phase(S_ST1); end
                        else begin m_stage = 3; next_data_byte(); end
                    end
                    2'd2: begin
                        m_stage = 3;
                        if (m_left != 0) begin m_bcnt = 0; load_phase(S_RXL); end
                        else load_phase(S_SP1);
                    end
                    default: next_data_byte();
                endcase
            end
            S_RXL: load_phase(S_RXH);
            S_RXH: begin
                m_sreg = {m_sreg[6:0], sda};
                m_bcnt++;
                if (m_bcnt < 8) load_phase(S_RXL);
                else begin m_got_byte = 1; m_left--; load_phase(S_RXE); end
            end
            S_RXE: load_phase(S_RAS);
            S_RAS: load_phase(S_RAH);
            S_RAH: load_phase(S_RAL);
            S_RAL: begin
                if (m_left != 0) begin m_bcnt = 0; load_phase(S_RXL); end
                else load_phase(S_SP1);
            end
            S_SP1: load_phase(S_SP2);
            S_SP2: load_phase(S_SP3);
            S_SP3: load_phase(S_SP4);
            S_SP4: begin m_ph = S_IDLE; m_got_done = 1; end
            default: m_ph = S_IDLE;
        endcase
    endfunction

    // one bus tick: returns the line result packed as on o_m_axis_tdata
    function automatic logic [15:0] bus_tick(t_row r);
        logic o_scl, o_sda, o_dir, o_need;
        m_got_byte = 0; m_got_done = 0;
        if (m_ph == S_IDLE && (r.kind == REQ_WRITE || r.kind == REQ_READ)) begin
            m_dev = {1'b0, r.dev}; m_regi = r.regi; m_left = r.len;
            m_rd = (r.kind == REQ_READ); m_fail = 0; m_stage = 0;
            load_phase(S_ST1);
        end else if (m_ph == S_WAIT && r.kind == REQ_BYTE) begin
            m_sreg = r.wbyte; m_left--; m_bcnt = 0;
            load_phase(S_TXS);
        end
        o_scl = m_scl; o_dir = m_dir;
        o_sda = m_dir ? m_sda : 1'b1;
        o_need = (m_ph == S_WAIT);
        if (m_ph == S_POLL) begin
            if (m_tcnt != 0) m_tcnt--;
            if (m_tcnt == 0) begin
                if (!r.sda) load_phase(S_AKL);
                else if (m_pcnt >= m_timeout) begin m_fail = 1; load_phase(S_SP1); end
                else begin
                    m_pcnt++;
                    m_tcnt = (m_poll_ticks != 0) ? {4'd0, m_poll_ticks} : 8'd1;
                end
            end
        end else if (m_ph != S_IDLE && m_ph != S_WAIT) begin
            if (m_tcnt != 0) m_tcnt--;
            if (m_tcnt == 0) phase_done(r.sda);
        end
        return {m_ph != S_IDLE, m_got_done & m_fail, m_got_done, o_need, m_got_byte,
                m_got_byte ? m_sreg : 8'd0, o_dir, o_sda, o_scl};
    endfunction

    // random request shaped by the state the bus is in
    function automatic t_row pick_request(logic draining);
        t_row r;
        int roll;
        roll = $urandom_range(0, 99);
        r.dev = 7'($urandom); r.regi = 8'($urandom); r.wbyte = 8'($urandom);
        r.len = 8'($urandom_range(0, 3));
        r.sda = 1'($urandom);
        r.typed = 0; r.want = '0;
        if (m_ph == S_POLL) r.sda = ($urandom_range(0, 99) < nack_pct);
        if (draining) begin
            r.kind = (m_ph == S_WAIT) ? REQ_BYTE : REQ_TICK;
            if (m_ph == S_POLL) r.sda = 0;
        end else if (m_ph == S_IDLE) begin
            r.kind = roll < 40 ? REQ_WRITE : roll < 80 ? REQ_READ :
                     roll < 90 ? REQ_TICK : REQ_BYTE;
        end else if (m_ph == S_WAIT) begin
            r.kind = roll < 85 ? REQ_BYTE : roll < 93 ? REQ_TICK : REQ_READ;
        end else begin
            r.kind = roll < 90 ? REQ_TICK : roll < 94 ? REQ_WRITE :
                     roll < 97 ? REQ_READ : REQ_BYTE;
        end
        return r;
    endfunction

    // push one request, with bursts and gaps on the sending side
    task automatic send_request(t_row r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.kind;
        i_s_axis_tdata  <= {r.sda, r.wbyte, r.len, r.regi, r.dev};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        begin
            logic [15:0] res;
            res = bus_tick(r);
            line_results.push_back(r.typed ? r.want : res);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE_TICKS: m_phase_ticks = val;
            CFG_ACK_TIMEOUT: m_timeout = val;
            default:         m_poll_ticks = val[3:0];
        endcase
        @(negedge i_clk);
    endtask

    // finish the transaction in flight, then let the pipeline empty
    task automatic settle();
        while (m_ph != S_IDLE) send_request(pick_request(1'b1));
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (line_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    t_row directed[$];

    initial begin
        int cfgs[4][4];
        m_phase_ticks = PHASE_TICKS_RST; m_timeout = ACK_TIMEOUT_RST; m_poll_ticks = ACK_POLL_RST;
        m_ph = S_IDLE; m_tcnt = 0; m_bcnt = 0; m_sreg = 0; m_left = 0; m_pcnt = 0;
        m_rd = 0; m_dev = 0; m_regi = 0; m_stage = 0; m_fail = 0;
        m_scl = 1; m_sda = 1; m_dir = 1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short bus phases keep whole transactions within the request budget
        write_reg(CFG_PHASE_TICKS, 8'd1);

        // idle tick, stray byte, write start, read ignored while busy
        directed.push_back('{REQ_TICK,  7'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1, 16'h0007});
        directed.push_back('{REQ_BYTE,  7'h00, 8'h00, 8'd0, 8'hFF, 1'b1, 1'b1, 16'h0007});
        directed.push_back('{REQ_WRITE, 7'h7F, 8'hFF, 8'd1, 8'h00, 1'b0, 1'b1, 16'h8007});
        directed.push_back('{REQ_READ,  7'h00, 8'h00, 8'd1, 8'h00, 1'b1, 1'b1, 16'h8007});
        foreach (directed[i]) send_request(directed[i]);
        settle();
        directed.delete();
        directed.push_back('{REQ_READ,  7'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1, 16'h8007});
        directed.push_back('{REQ_WRITE, 7'h55, 8'hAA, 8'd5, 8'hFF, 1'b0, 1'b1, 16'h8007});
        foreach (directed[i]) send_request(directed[i]);
        settle();
        directed.delete();
        directed.push_back('{REQ_WRITE, 7'h2A, 8'h55, 8'd0, 8'h00, 1'b0, 1'b0, 16'h0});
        directed.push_back('{REQ_READ,  7'h7F, 8'hFF, 8'd1, 8'h00, 1'b1, 1'b0, 16'h0});
        foreach (directed[i]) begin
            send_request(directed[i]);
            settle();
        end

        // phase ticks, timeout, poll ticks, nack percentage
        cfgs = '{'{1, 1, 1, 50}, '{0, 0, 0, 40}, '{2, 3, 15, 60}, '{1, 255, 1, 3}};
        foreach (cfgs[p]) begin
            write_reg(CFG_PHASE_TICKS, 8'(cfgs[p][0]));
            write_reg(CFG_ACK_TIMEOUT, 8'(cfgs[p][1]));
            write_reg(CFG_ACK_POLL, 8'(cfgs[p][2]));
            nack_pct = cfgs[p][3];
            repeat (40) send_request(pick_request(1'b0));
            settle();
        end

        if (errors == 0) begin
            $display("i2c_master_register_access_tb passed");
        end else begin
            $display("i2c_master_register_access_tb failed");
        end
        $finish;
    end

    // result side stalls in stretches of random density
    int stall_pct = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void check_field(string nm, int got, int want);
        if (got != want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, nm, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (line_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $realtime, o_m_axis_tdata);
                errors++;
            end else begin
                logic [15:0] w;
                w = line_results.pop_front();
                check_field("scl_level", o_m_axis_tdata[0], w[0]);
                check_field("sda_drive", o_m_axis_tdata[1], w[1]);
                check_field("sda_is_output", o_m_axis_tdata[2], w[2]);
                check_field("read_byte", o_m_axis_tdata[10:3], w[10:3]);
                check_field("read_valid", o_m_axis_tdata[11], w[11]);
                check_field("need_write_byte", o_m_axis_tdata[12], w[12]);
                check_field("done_res", o_m_axis_tdata[13], w[13]);
                check_field("status", o_m_axis_tdata[14], w[14]);
                check_field("busy_res", o_m_axis_tdata[15], w[15]);
            end
        end
        in_accept = (i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready);
        idle_cycles = (in_accept || !i_rst_n) ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("i2c_master_register_access_tb failed");
            $finish;
        end
    end
endmodule
